// File: design/sida_pkg.sv
// Package for the signed integer to decimal ASCII unit.
// Holds the widths, the ASCII codes and the sequencer state type.
// It depends on nothing else.
package sida_pkg;

	localparam int unsigned BIN_W      = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
	localparam int unsigned CHAR_W     = 6;

	localparam logic [CHAR_W-1:0] CODE_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CODE_MINUS = CHAR_W'(45);

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

endpackage

// File: design/sida_bcd_conv.sv
// Iterative binary to BCD converter using the shift and add-three method.
// One bit of the magnitude is shifted in per cycle; uses sida_pkg.
module sida_bcd_conv
	import sida_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BIN_W-1:0] mag,
	output logic             done,
	output bcd_t             bcd
);

	localparam int unsigned CNT_W = $clog2(BIN_W);

	logic [BIN_W-1:0] bin_q;
	bcd_t             bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	bcd_t             bcd_adj;

	// Every digit of five or more gets three added before the shift doubles it.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= DIGIT_W'(5)) ? bcd_q[i] + DIGIT_W'(3) : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(BIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			{bcd_q, bin_q} <= {bcd_adj, bin_q} << 1;
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// File: design/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// The BCD conversion shifts one bit per cycle through sida_bcd_conv. A new value
// is taken only in idle, after the last character of the previous one has gone out;
// the text is 1 to 11 characters long. Asynchronous active-low reset returns the
// sequencer to idle.
module signed_int_to_decimal_ascii_unit
	import sida_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BIN_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	state_t           state_q, state_d;
	logic             neg_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] lead_idx;
	logic [BIN_W-1:0] mag;
	logic             conv_start;
	logic             conv_done;
	bcd_t             bcd;

	// Two's complement negation also gives the right unsigned magnitude for the
	// most negative value.
	assign mag        = value[BIN_W-1] ? (~value + BIN_W'(1)) : value;
	assign conv_start = in_valid && in_ready;

	sida_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// Highest non-zero digit; zero leaves the index on the units digit.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[i] != '0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		character = CODE_ZERO + CHAR_W'(bcd[idx_q]);
		last      = (idx_q == '0);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = neg_q ? ST_SIGN : ST_DIGITS;
				end
			end
			ST_SIGN: begin
				out_valid = 1'b1;
				character = CODE_MINUS;
				last      = 1'b0;
				if (out_ready) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				out_valid = 1'b1;
				if (out_ready && idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (conv_start) begin
				neg_q <= value[BIN_W-1];
			end
			if (state_q == ST_CONV && conv_done) begin
				idx_q <= lead_idx;
			end else if (state_q == ST_DIGITS && out_ready && idx_q != '0) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

endmodule

// File: tb/signed_int_to_decimal_ascii_unit_tb.sv
// Testbench for signed_int_to_decimal_ascii_unit: each word sent in is predicted as its decimal
// text and every character that comes out is checked against that prediction, under random gaps.
// Depends on sida_pkg and the signed_int_to_decimal_ascii_unit RTL.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_unit_tb;
	import sida_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              is_last;
	} text_char_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [BIN_W-1:0]  value;
	logic              out_valid;
	logic              out_ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	text_char_t  pending_text[$];
	int unsigned error_count;
	int unsigned cycle_count;
	bit          gaps_on;
	bit          hold_request;
	int unsigned hold_cycles;

	signed_int_to_decimal_ascii_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Works out the characters a word should produce and queues them in output order.
	function automatic void queue_decimal_text(input logic [BIN_W-1:0] v);
		logic [BIN_W-1:0] magnitude;
		logic [3:0]       digit_list [NUM_DIGITS];
		int               n;
		text_char_t       c;
		magnitude = v[BIN_W-1] ? -v : v;
		n = 0;
		do begin
			digit_list[n] = 4'(magnitude % 10);
			n++;
			magnitude = magnitude / 10;
		end while (magnitude != 0 && n < NUM_DIGITS);
		if (v[BIN_W-1]) begin
			c.code = CODE_MINUS;
			c.is_last = 1'b0;
			pending_text.push_back(c);
		end
		for (int k = n - 1; k >= 0; k--) begin
			c.code = CHAR_W'(CODE_ZERO + digit_list[k]);
			c.is_last = (k == 0);
			pending_text.push_back(c);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_value(input logic [BIN_W-1:0] v);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(6, 0) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		value = v;
		do @(posedge clk); while (!in_ready);
		queue_decimal_text(v);
		@(negedge clk);
	endtask

	task automatic test_corner_values();
		logic [BIN_W-1:0] corner_values [$];
		corner_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10, 32'd99,
			32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			32'd999999999, -32'd999999999, 32'h5555_5555, 32'hAAAA_AAAA, -32'd1000000000,
			-32'd9};
		gaps_on = 1'b1;
		foreach (corner_values[i])
			send_value(corner_values[i]);
	endtask

	// Mixes fully random words with values of a chosen digit count and values
	// around powers of ten, so that every text length and carry boundary is hit.
	task automatic test_random_values(input int unsigned count);
		int unsigned      kind;
		int unsigned      n;
		int unsigned      lo;
		int unsigned      hi;
		int unsigned      p;
		logic [BIN_W-1:0] magnitude;
		logic [BIN_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(3, 0);
			if (kind == 0) begin
				v = $urandom;
			end else if (kind == 3) begin
				p = 1;
				repeat ($urandom_range(9, 0)) p = p * 10;
				magnitude = p + $urandom_range(2, 0) - 1;
				v = $urandom_range(1, 0) ? -magnitude : magnitude;
			end else begin
				n = $urandom_range(10, 1);
				p = 1;
				repeat (n - 1) p = p * 10;
				lo = (n == 1) ? 0 : p;
				hi = (n == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
				magnitude = $urandom_range(hi, lo);
				v = $urandom_range(1, 0) ? -magnitude : magnitude;
			end
			send_value(v);
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		gaps_on = 1'b0;
		test_random_values(count);
		gaps_on = 1'b1;
	endtask

	// The receiver stops for a long stretch while words keep being offered,
	// so the unit fills up and must hold its input off.
	task automatic test_output_hold(input int unsigned count);
		hold_cycles = 400;
		hold_request = 1'b1;
		test_random_values(count);
	endtask

	// Receiver: a random stall before each character while gaps are on, or a long hold when asked.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_request = 1'b0;
			end
			stall = gaps_on ? $urandom_range(6, 0) : 0;
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_text.size() == 0) begin
				$error("character: no result expected, got %0d", character);
				error_count++;
			end else begin
				want = pending_text.pop_front();
				if (character !== want.code) begin
					$error("character: expected %0d, got %0d", want.code, character);
					error_count++;
				end
				if (last !== want.is_last) begin
					$error("last: expected %0d, got %0d", want.is_last, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("signed_int_to_decimal_ascii_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		gaps_on = 1'b1;
		hold_request = 1'b0;
		hold_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_values();
		test_random_values(310);
		test_back_to_back(60);
		test_output_hold(40);
		in_valid = 1'b0;

		while (pending_text.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("signed_int_to_decimal_ascii_unit_tb OK");
		end else begin
			$display("signed_int_to_decimal_ascii_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: signed_int_to_decimal_ascii_unit.f
design/sida_pkg.sv
design/sida_bcd_conv.sv
design/signed_int_to_decimal_ascii_unit.sv
tb/signed_int_to_decimal_ascii_unit_tb.sv
